/* hw/rtl/indexed_insert_remove_array_assert.svh */
// assertion macros used by the rtl file iira_ctrl.sv
`ifndef INDEXED_INSERT_REMOVE_ARRAY_ASSERT_SVH
`define INDEXED_INSERT_REMOVE_ARRAY_ASSERT_SVH

// condition implies consequence in the same cycle
`define IIRA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define IIRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/iira_pkg.sv */
// package: types, codes and sizes of the insert/remove array
package iira_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 6;
	localparam int DATA_W   = 32;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BOUNDS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [CNT_W-1:0] idx;
		word_t            wdata;
	} shift_ctl_t;

endpackage

/* hw/rtl/iira_req_if.sv */
// request channel: operation, index and write word
interface iira_req_if;
	logic                 valid;
	logic                 ready;
	logic [1:0]           operation;
	logic [5:0]           element_index;
	logic signed [31:0]   write_value;

	modport source(output valid, operation, element_index, write_value, input ready);
	modport sink(input valid, operation, element_index, write_value, output ready);
endinterface

/* hw/rtl/iira_rsp_if.sv */
// response channel: read word, status and entry count
interface iira_rsp_if;
	logic                 valid;
	logic                 ready;
	logic signed [31:0]   read_value;
	logic [1:0]           status;
	logic [5:0]           entry_count;

	modport source(output valid, read_value, status, entry_count, input ready);
	modport sink(input valid, read_value, status, entry_count, output ready);
endinterface

/* hw/rtl/indexed_insert_remove_array.sv */
// top level: ordered store of signed words with insert, remove and read
// Holds up to 32 signed 32-bit words in a chain of cells, each cell loading
// from its left or right neighbour so that an insert or remove shifts the
// whole tail on the same clock edge. One request is taken per cycle; its word
// comes out of the response register in the cycle after acceptance, and a new
// request is taken whenever that register is empty or being drained. Insert
// past the count or remove/read at or past the count reports out of bounds
// (a failed read returns -1); insert into a full store reports full. Every
// response carries the entry count after the request. Contents below the
// count are always defined; cells above it hold stale data.
module indexed_insert_remove_array (
	input  logic       clk,
	input  logic       arst_n,
	iira_req_if.sink   req,
	iira_rsp_if.source rsp
);

	iira_pkg::shift_ctl_t shift;
	iira_pkg::word_t      cell_data [iira_pkg::CAPACITY];
	iira_pkg::word_t      rd_data;

	assign rd_data = cell_data[req.element_index[iira_pkg::IDX_W-1:0]];

	iira_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.rd_data (rd_data),
		.shift   (shift)
	);

	for (genvar g = 0; g < iira_pkg::CAPACITY; g++) begin : g_cell
		iira_pkg::word_t left_w;
		iira_pkg::word_t right_w;

		if (g == 0) begin : g_first
			assign left_w = shift.wdata;
		end else begin : g_inner_l
			assign left_w = cell_data[g-1];
		end

		if (g == iira_pkg::CAPACITY - 1) begin : g_last
			assign right_w = cell_data[g];
		end else begin : g_inner_r
			assign right_w = cell_data[g+1];
		end

		iira_cell u_cell (
			.clk        (clk),
			.shift      (shift),
			.pos        (iira_pkg::CNT_W'(g)),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[g])
		);
	end

endmodule

/* hw/rtl/iira_cell.sv */
// one storage cell of the shift chain
module iira_cell (
	input  logic                      clk,
	input  iira_pkg::shift_ctl_t      shift,
	input  logic [iira_pkg::CNT_W-1:0] pos,
	input  iira_pkg::word_t           left_data,
	input  iira_pkg::word_t           right_data,
	output iira_pkg::word_t           data
);

	iira_pkg::word_t data_q;

	always_ff @(posedge clk) begin
		if (shift.ins && (pos >= shift.idx)) begin
			data_q <= (pos == shift.idx) ? shift.wdata : left_data;
		end else if (shift.rem && (pos >= shift.idx)) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;

endmodule

/* hw/rtl/iira_ctrl.sv */
// request decode, entry count and response register
module iira_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	iira_req_if.sink             req,
	iira_rsp_if.source           rsp,
	input  iira_pkg::word_t      rd_data,
	output iira_pkg::shift_ctl_t shift
);

	logic [iira_pkg::CNT_W-1:0] count_q;
	logic [iira_pkg::CNT_W-1:0] count_d;
	logic                       rsp_valid_q;
	iira_pkg::word_t            read_value_q;
	iira_pkg::status_t          status_q;
	iira_pkg::word_t            rd_d;
	iira_pkg::status_t          st_d;
	logic                       ins_ok;
	logic                       rem_ok;
	logic                       acc;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	always_comb begin
		rd_d   = '0;
		st_d   = iira_pkg::ST_OK;
		ins_ok = 1'b0;
		rem_ok = 1'b0;
		unique case (iira_pkg::op_t'(req.operation))
			iira_pkg::OP_INSERT: begin
				if (req.element_index > count_q) begin
					st_d = iira_pkg::ST_BOUNDS;
				end else if (count_q == iira_pkg::CNT_W'(iira_pkg::CAPACITY)) begin
					st_d = iira_pkg::ST_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			iira_pkg::OP_REMOVE: begin
				if (req.element_index >= count_q) begin
					st_d = iira_pkg::ST_BOUNDS;
				end else begin
					rem_ok = 1'b1;
				end
			end
			iira_pkg::OP_READ: begin
				if (req.element_index >= count_q) begin
					st_d = iira_pkg::ST_BOUNDS;
					rd_d = '1;
				end else begin
					rd_d = rd_data;
				end
			end
			default: begin
				st_d = iira_pkg::ST_OK;
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (acc && ins_ok) begin
			count_d = count_q + iira_pkg::CNT_W'(1);
		end else if (acc && rem_ok) begin
			count_d = count_q - iira_pkg::CNT_W'(1);
		end
	end

	assign shift.ins   = acc && ins_ok;
	assign shift.rem   = acc && rem_ok;
	assign shift.idx   = req.element_index;
	assign shift.wdata = req.write_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			read_value_q <= rd_d;
			status_q     <= st_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_value  = read_value_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = count_q;

	`include "indexed_insert_remove_array_assert.svh"

	`IIRA_ASSERT_SAME(a_count_in_range, 1'b1, count_q <= iira_pkg::CNT_W'(iira_pkg::CAPACITY), "entry count above capacity")
	`IIRA_ASSERT_NEXT(a_insert_grows, acc && ins_ok, count_q == $past(count_q) + iira_pkg::CNT_W'(1), "insert did not grow the count")
	`IIRA_ASSERT_NEXT(a_remove_shrinks, acc && rem_ok, count_q == $past(count_q) - iira_pkg::CNT_W'(1), "remove did not shrink the count")
	`IIRA_ASSERT_SAME(a_full_only_at_capacity, acc && (st_d == iira_pkg::ST_FULL), count_q == iira_pkg::CNT_W'(iira_pkg::CAPACITY), "full status below capacity")
	`IIRA_ASSERT_NEXT(a_word_follows_accept, acc, rsp.valid, "accepted word gave no response")

endmodule

/* sim/tb_indexed_insert_remove_array.sv */
// testbench: indexed insert/remove array checked against its own shadow store
module tb_indexed_insert_remove_array;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int NUM_ROWS = 27;
	localparam int PHASE_ITEMS = 350;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		iira_pkg::word_t            read_value;
		iira_pkg::status_t          status;
		logic [iira_pkg::CNT_W-1:0] entry_count;
	} result_t;

	typedef struct {
		logic [1:0]        op;
		logic [5:0]        idx;
		iira_pkg::word_t   wdata;
		bit                fill;
		bit                typed;
		iira_pkg::word_t   exp_value;
		iira_pkg::status_t exp_status;
		int                exp_count;
	} script_row_t;

	typedef enum {GROW, SHRINK, MIXED} drift_t;

	logic clk;
	logic arst_n;

	iira_req_if req_ch();
	iira_rsp_if rsp_ch();

	indexed_insert_remove_array dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	iira_pkg::word_t shadow_store [iira_pkg::CAPACITY];
	int              shadow_count;
	result_t         pending_results [$];
	bit              typed_flag;
	result_t         typed_want;
	result_t         arrived_want;
	result_t         fresh;
	int              send_idle_pct;
	int              recv_stall_pct;
	int              mismatch_count;
	int              accepted_count;
	int              checked_count;
	int              peak_count;
	int              full_rejects;
	int              bounds_rejects;

	int idle_by_phase  [4] = '{0, 76, 0, 21};
	int stall_by_phase [4] = '{0, 0, 76, 21};

	script_row_t script_rows [NUM_ROWS] = '{
		'{iira_pkg::OP_READ, 6'd0, 0, 1'b0, 1'b1, -1, iira_pkg::ST_BOUNDS, 0},
		'{iira_pkg::OP_REMOVE, 6'd0, 0, 1'b0, 1'b1, 0, iira_pkg::ST_BOUNDS, 0},
		'{iira_pkg::OP_INSERT, 6'd1, 5, 1'b0, 1'b1, 0, iira_pkg::ST_BOUNDS, 0},
		'{OP_UNUSED, 6'd0, 0, 1'b0, 1'b1, 0, iira_pkg::ST_OK, 0},
		'{iira_pkg::OP_INSERT, 6'd0, 32'h7fffffff, 1'b0, 1'b1, 0, iira_pkg::ST_OK, 1},
		'{iira_pkg::OP_INSERT, 6'd0, 32'h80000000, 1'b0, 1'b1, 0, iira_pkg::ST_OK, 2},
		'{iira_pkg::OP_INSERT, 6'd2, -1, 1'b0, 1'b1, 0, iira_pkg::ST_OK, 3},
		'{iira_pkg::OP_READ, 6'd0, 0, 1'b0, 1'b1, 32'h80000000, iira_pkg::ST_OK, 3},
		'{iira_pkg::OP_READ, 6'd1, 0, 1'b0, 1'b1, 32'h7fffffff, iira_pkg::ST_OK, 3},
		'{iira_pkg::OP_READ, 6'd2, 0, 1'b0, 1'b1, -1, iira_pkg::ST_OK, 3},
		'{iira_pkg::OP_READ, 6'd63, 0, 1'b0, 1'b1, -1, iira_pkg::ST_BOUNDS, 3},
		'{iira_pkg::OP_INSERT, 6'd63, 0, 1'b0, 1'b1, 0, iira_pkg::ST_BOUNDS, 3},
		'{iira_pkg::OP_INSERT, 6'd3, 32'h5a5a5a5a, 1'b0, 1'b1, 0, iira_pkg::ST_OK, 4},
		'{iira_pkg::OP_REMOVE, 6'd1, 0, 1'b0, 1'b1, 0, iira_pkg::ST_OK, 3},
		'{iira_pkg::OP_READ, 6'd1, 0, 1'b0, 1'b1, -1, iira_pkg::ST_OK, 3},
		'{iira_pkg::OP_REMOVE, 6'd3, 0, 1'b0, 1'b1, 0, iira_pkg::ST_BOUNDS, 3},
		'{iira_pkg::OP_REMOVE, 6'd2, 0, 1'b0, 1'b1, 0, iira_pkg::ST_OK, 2},
		'{iira_pkg::OP_INSERT, 6'd0, 0, 1'b1, 1'b0, 0, iira_pkg::ST_OK, 0},
		'{iira_pkg::OP_INSERT, 6'd32, 1, 1'b0, 1'b1, 0, iira_pkg::ST_FULL, 32},
		'{iira_pkg::OP_INSERT, 6'd0, 1, 1'b0, 1'b1, 0, iira_pkg::ST_FULL, 32},
		'{iira_pkg::OP_INSERT, 6'd33, 1, 1'b0, 1'b1, 0, iira_pkg::ST_BOUNDS, 32},
		'{iira_pkg::OP_READ, 6'd32, 0, 1'b0, 1'b1, -1, iira_pkg::ST_BOUNDS, 32},
		'{iira_pkg::OP_READ, 6'd31, 0, 1'b0, 1'b0, 0, iira_pkg::ST_OK, 0},
		'{iira_pkg::OP_READ, 6'd0, 0, 1'b0, 1'b0, 0, iira_pkg::ST_OK, 0},
		'{iira_pkg::OP_REMOVE, 6'd31, 0, 1'b0, 1'b1, 0, iira_pkg::ST_OK, 31},
		'{iira_pkg::OP_REMOVE, 6'd0, 0, 1'b0, 1'b1, 0, iira_pkg::ST_OK, 30},
		'{OP_UNUSED, 6'd63, -1, 1'b0, 1'b1, 0, iira_pkg::ST_OK, 30}
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic result_t apply_request(input logic [1:0] op, input logic [5:0] idx,
			input iira_pkg::word_t wdata);
		result_t r;
		int      i;
		r.read_value = '0;
		r.status = iira_pkg::ST_OK;
		case (op)
			iira_pkg::OP_INSERT: begin
				if (idx > shadow_count) begin
					r.status = iira_pkg::ST_BOUNDS;
				end else if (shadow_count >= iira_pkg::CAPACITY) begin
					r.status = iira_pkg::ST_FULL;
				end else begin
					for (i = shadow_count; i > idx; i--)
						shadow_store[i] = shadow_store[i-1];
					shadow_store[idx] = wdata;
					shadow_count++;
				end
			end
			iira_pkg::OP_REMOVE: begin
				if (idx >= shadow_count) begin
					r.status = iira_pkg::ST_BOUNDS;
				end else begin
					for (i = idx; i + 1 < shadow_count; i++)
						shadow_store[i] = shadow_store[i+1];
					shadow_count--;
				end
			end
			iira_pkg::OP_READ: begin
				if (idx >= shadow_count) begin
					r.status = iira_pkg::ST_BOUNDS;
					r.read_value = -1;
				end else begin
					r.read_value = shadow_store[idx];
				end
			end
			default: ;
		endcase
		r.entry_count = iira_pkg::CNT_W'(shadow_count);
		if (shadow_count > peak_count)
			peak_count = shadow_count;
		if (r.status == iira_pkg::ST_FULL)
			full_rejects++;
		if (r.status == iira_pkg::ST_BOUNDS)
			bounds_rejects++;
		return r;
	endfunction

	// response check first, then prediction of the word taken in this cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				checked_count++;
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: unexpected result value=%0d status=%0d count=%0d",
							$time, rsp_ch.read_value, rsp_ch.status, rsp_ch.entry_count);
				end else begin
					arrived_want = pending_results.pop_front();
					if (rsp_ch.read_value !== arrived_want.read_value
							|| rsp_ch.status !== arrived_want.status
							|| rsp_ch.entry_count !== arrived_want.entry_count) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
								$time, arrived_want.read_value, arrived_want.status,
								arrived_want.entry_count, rsp_ch.read_value,
								rsp_ch.status, rsp_ch.entry_count);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				fresh = apply_request(req_ch.operation, req_ch.element_index, req_ch.write_value);
				if (typed_flag)
					fresh = typed_want;
				pending_results.push_back(fresh);
				accepted_count++;
			end
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic send_request(input logic [1:0] op, input logic [5:0] idx,
			input iira_pkg::word_t wdata, input bit typed, input result_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.element_index <= idx;
		req_ch.write_value <= wdata;
		typed_flag <= typed;
		typed_want <= want;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic fill_store();
		while (shadow_count < iira_pkg::CAPACITY)
			send_request(iira_pkg::OP_INSERT, 6'($urandom_range(0, shadow_count)),
				iira_pkg::word_t'($urandom), 1'b0, '0);
	endtask

	// bursts drift the fill level up or down so that both empty and full are reached
	task automatic run_random(input int n_items);
		drift_t     mode;
		int         burst;
		int         pick;
		int         ins_pct;
		int         rem_pct;
		int         n;
		logic [1:0] op;
		logic [5:0] idx;
		burst = 0;
		mode = MIXED;
		for (n = 0; n < n_items; n++) begin
			if (burst == 0) begin
				mode = drift_t'($urandom_range(0, 2));
				burst = $urandom_range(10, 60);
			end
			burst--;
			case (mode)
				GROW: begin
					ins_pct = 65;
					rem_pct = 15;
				end
				SHRINK: begin
					ins_pct = 15;
					rem_pct = 65;
				end
				default: begin
					ins_pct = 35;
					rem_pct = 30;
				end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				op = 2'($urandom_range(0, 3));
				idx = 6'($urandom_range(0, 63));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < ins_pct)
					op = iira_pkg::OP_INSERT;
				else if (pick < ins_pct + rem_pct)
					op = iira_pkg::OP_REMOVE;
				else
					op = iira_pkg::OP_READ;
				if (op == iira_pkg::OP_INSERT)
					idx = 6'($urandom_range(0, shadow_count));
				else if (shadow_count == 0 || $urandom_range(0, 19) == 0)
					idx = 6'(shadow_count + $urandom_range(0, 1));
				else
					idx = 6'($urandom_range(0, shadow_count - 1));
			end
			send_request(op, idx, iira_pkg::word_t'($urandom), 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		int      r;
		int      ph;
		result_t want;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = iira_pkg::OP_INSERT;
		req_ch.element_index = '0;
		req_ch.write_value = '0;
		typed_flag = 1'b0;
		typed_want = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		shadow_count = 0;
		mismatch_count = 0;
		accepted_count = 0;
		checked_count = 0;
		peak_count = 0;
		full_rejects = 0;
		bounds_rejects = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (r = 0; r < NUM_ROWS; r++) begin
			if (script_rows[r].fill) begin
				fill_store();
			end else begin
				want.read_value = script_rows[r].exp_value;
				want.status = script_rows[r].exp_status;
				want.entry_count = iira_pkg::CNT_W'(script_rows[r].exp_count);
				send_request(script_rows[r].op, script_rows[r].idx, script_rows[r].wdata,
					script_rows[r].typed, want);
			end
		end

		for (ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_by_phase[ph];
			recv_stall_pct = stall_by_phase[ph];
			run_random(PHASE_ITEMS);
		end
		req_ch.valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		$display("%0d requests accepted, %0d results checked, %0d mismatches",
			accepted_count, checked_count, mismatch_count);
		$display("peak fill %0d of %0d, %0d full rejections, %0d out-of-range requests",
			peak_count, iira_pkg::CAPACITY, full_rejects, bounds_rejects);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

/* indexed_insert_remove_array.f */
+incdir+hw/rtl
hw/rtl/iira_pkg.sv
hw/rtl/iira_req_if.sv
hw/rtl/iira_rsp_if.sv
hw/rtl/iira_cell.sv
hw/rtl/iira_ctrl.sv
hw/rtl/indexed_insert_remove_array.sv
sim/tb_indexed_insert_remove_array.sv
